// ===== hdl/clt_pkg.sv =====
// Types and constants shared by the command line tokenizer modules.
// No dependencies.
package clt_pkg;

	localparam int POS_W = 13;
	localparam int IDX_W = 12;

	// Bytes past this position are dropped; the token count saturates here.
	localparam logic [POS_W-1:0] LINE_LIM  = POS_W'(4096);
	localparam logic [IDX_W-1:0] TOKEN_LIM = IDX_W'(2048);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	localparam logic [1:0] TOK_WORD = 2'd0;
	localparam logic [1:0] TOK_FLAG = 2'd1;
	localparam logic [1:0] TOK_LIT  = 2'd2;

	localparam logic REC_TOKEN  = 1'b0;
	localparam logic REC_ACTIVE = 1'b1;

	typedef enum logic [3:0] {
		ST_GAP  = 4'b0001,
		ST_WORD = 4'b0010,
		ST_DQ   = 4'b0100,
		ST_SQ   = 4'b1000
	} scan_state_t;

	typedef struct packed {
		logic             has_byte;
		logic [7:0]       ch;
		logic [POS_W-1:0] cursor;
		logic             end_of_line;
	} item_t;

	typedef struct packed {
		logic             record_kind;
		logic [1:0]       tok_type;
		logic             closed;
		logic [POS_W-1:0] span_start;
		logic [POS_W-1:0] span_len;
		logic [POS_W-1:0] prefix_start;
		logic [POS_W-1:0] prefix_len;
		logic [IDX_W-1:0] token_index;
		logic             is_new_token;
		logic             inside_quotes;
		logic             last;
	} record_t;

	// One queue entry: a finished token and/or the end-of-line match summary.
	typedef struct packed {
		logic             tok_v;
		logic [1:0]       tok_type;
		logic             tok_closed;
		logic [POS_W-1:0] tok_start;
		logic [POS_W-1:0] tok_len;
		logic [IDX_W-1:0] tok_idx;
		logic             act_v;
		logic             m_found;
		logic [IDX_W-1:0] m_idx;
		logic [POS_W-1:0] m_start;
		logic [POS_W-1:0] m_end;
		logic             m_lit;
		logic [POS_W-1:0] cur;
		logic             inq;
		logic [IDX_W-1:0] count;
	} entry_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ===== hdl/clt_front.sv =====
// Front end: accepts line bytes, runs the quote/escape scanner and tracks the
// token under the cursor. Produces queue entries. Depends on clt_pkg.
module clt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_stall,
	input  clt_pkg::item_t item,
	output logic           push,
	output clt_pkg::entry_t entry
);
	import clt_pkg::*;

	scan_state_t      st_q, st_n;
	logic             esc_q, esc_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] ts_q, ts_n;
	logic             fl_q, fl_n;
	logic [IDX_W-1:0] cnt_q, cnt_n;
	logic             mf_q, mf_n;
	logic [IDX_W-1:0] mi_q, mi_n;
	logic [POS_W-1:0] ms_q, ms_n;
	logic [POS_W-1:0] me_q, me_n;
	logic             ml_q, ml_n;

	logic             take, emit, e_closed, hit, inq, accept;
	logic [1:0]       e_type;
	logic [POS_W-1:0] e_end, cur_c;

	assign accept = item_valid && !item_stall;

	always_comb begin
		take  = item.has_byte && (pos_q < LINE_LIM);
		pos_n = pos_q + POS_W'(take);
		cur_c = (item.end_of_line && item.cursor > pos_n) ? pos_n : item.cursor;

		st_n     = st_q;
		esc_n    = esc_q;
		ts_n     = ts_q;
		fl_n     = fl_q;
		emit     = 1'b0;
		e_type   = TOK_WORD;
		e_closed = 1'b1;
		e_end    = pos_q;

		if (take) begin
			if (esc_q) begin
				esc_n = 1'b0;
			end else if (item.ch == CH_BSLASH && st_q != ST_SQ) begin
				esc_n = 1'b1;
			end else begin
				unique case (st_q)
					ST_GAP: begin
						if (!is_space(item.ch)) begin
							ts_n = pos_q;
							fl_n = 1'b0;
							if (item.ch == CH_DQUOTE) begin
								st_n = ST_DQ;
							end else if (item.ch == CH_SQUOTE) begin
								st_n = ST_SQ;
							end else begin
								st_n = ST_WORD;
								fl_n = (item.ch == CH_DASH);
							end
						end
					end
					ST_WORD: begin
						if (is_space(item.ch)) begin
							emit   = 1'b1;
							e_type = fl_q ? TOK_FLAG : TOK_WORD;
							e_end  = pos_q;
							st_n   = ST_GAP;
						end
					end
					ST_DQ: begin
						if (item.ch == CH_DQUOTE) begin
							emit   = 1'b1;
							e_type = TOK_LIT;
							e_end  = pos_n;
							st_n   = ST_GAP;
						end
					end
					ST_SQ: begin
						if (item.ch == CH_SQUOTE) begin
							emit   = 1'b1;
							e_type = TOK_LIT;
							e_end  = pos_n;
							st_n   = ST_GAP;
						end
					end
					default: st_n = ST_GAP;
				endcase
			end
		end

		inq = (st_n == ST_DQ) || (st_n == ST_SQ);

		// flush of a token left open at line end
		if (item.end_of_line && !emit) begin
			if (st_n == ST_WORD) begin
				emit   = 1'b1;
				e_type = fl_n ? TOK_FLAG : TOK_WORD;
				e_end  = pos_n;
			end else if (inq) begin
				emit     = 1'b1;
				e_type   = TOK_LIT;
				e_closed = 1'b0;
				e_end    = pos_n;
			end
		end

		hit  = emit && !mf_q && (cur_c >= ts_n) && (cur_c <= e_end);
		mf_n = mf_q || hit;
		mi_n = hit ? cnt_q : mi_q;
		ms_n = hit ? ts_n : ms_q;
		me_n = hit ? e_end : me_q;
		ml_n = hit ? (e_type == TOK_LIT) : ml_q;
		cnt_n = (emit && cnt_q < TOKEN_LIM) ? cnt_q + IDX_W'(1) : cnt_q;

		entry.tok_v      = emit;
		entry.tok_type   = e_type;
		entry.tok_closed = e_closed;
		entry.tok_start  = ts_n;
		entry.tok_len    = e_end - ts_n;
		entry.tok_idx    = cnt_q;
		entry.act_v      = item.end_of_line;
		entry.m_found    = mf_n;
		entry.m_idx      = mi_n;
		entry.m_start    = ms_n;
		entry.m_end      = me_n;
		entry.m_lit      = ml_n;
		entry.cur        = cur_c;
		entry.inq        = item.end_of_line && inq;
		entry.count      = cnt_n;
	end

	assign push = accept && (emit || item.end_of_line);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_GAP;
			esc_q <= 1'b0;
			pos_q <= '0;
			ts_q  <= '0;
			fl_q  <= 1'b0;
			cnt_q <= '0;
			mf_q  <= 1'b0;
			mi_q  <= '0;
			ms_q  <= '0;
			me_q  <= '0;
			ml_q  <= 1'b0;
		end else if (accept) begin
			if (item.end_of_line) begin
				st_q  <= ST_GAP;
				esc_q <= 1'b0;
				pos_q <= '0;
				ts_q  <= '0;
				fl_q  <= 1'b0;
				cnt_q <= '0;
				mf_q  <= 1'b0;
				mi_q  <= '0;
				ms_q  <= '0;
				me_q  <= '0;
				ml_q  <= 1'b0;
			end else begin
				st_q  <= st_n;
				esc_q <= esc_n;
				pos_q <= pos_n;
				ts_q  <= ts_n;
				fl_q  <= fl_n;
				cnt_q <= cnt_n;
				mf_q  <= mf_n;
				mi_q  <= mi_n;
				ms_q  <= ms_n;
				me_q  <= me_n;
				ml_q  <= ml_n;
			end
		end
	end

endmodule

// ===== hdl/clt_queue.sv =====
// Short register queue of entries between the front and back ends.
// Depends on clt_pkg.
module clt_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clt_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output clt_pkg::entry_t rdata
);
	import clt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/clt_back.sv =====
// Back end: turns queue entries into token and active records and holds
// them in the output register. Depends on clt_pkg.
module clt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  clt_pkg::entry_t head,
	output logic            pop,
	output logic            rec_valid,
	input  logic            rec_stall,
	output clt_pkg::record_t rec
);
	import clt_pkg::*;

	logic             tok_sent_q;
	logic             valid_q;
	record_t          rec_q;
	record_t          tok_rec, act_rec;
	logic             load, send_tok;
	logic [POS_W-1:0] top, pl_raw;

	assign load     = !empty && (!valid_q || !rec_stall);
	// token record goes first; the entry is popped with its last record
	assign send_tok = head.tok_v && !tok_sent_q;
	assign pop      = load && !(send_tok && head.act_v);

	always_comb begin
		tok_rec = '0;
		tok_rec.record_kind = REC_TOKEN;
		tok_rec.tok_type    = head.tok_type;
		tok_rec.closed      = head.tok_closed;
		tok_rec.span_start  = head.tok_start;
		tok_rec.span_len    = head.tok_len;
		tok_rec.token_index = head.tok_idx;

		top    = (head.cur < head.m_end) ? head.cur : head.m_end;
		pl_raw = (top > head.m_start) ? top - head.m_start : '0;

		act_rec = '0;
		act_rec.record_kind   = REC_ACTIVE;
		act_rec.inside_quotes = head.inq;
		act_rec.last          = 1'b1;
		if (head.m_found) begin
			act_rec.span_start  = head.m_start;
			act_rec.span_len    = head.m_end - head.m_start;
			act_rec.token_index = head.m_idx;
			// prefix of a literal skips its opening quote
			if (pl_raw != '0 && head.m_lit) begin
				act_rec.prefix_start = head.m_start + POS_W'(1);
				act_rec.prefix_len   = pl_raw - POS_W'(1);
			end else begin
				act_rec.prefix_start = head.m_start;
				act_rec.prefix_len   = pl_raw;
			end
			if (act_rec.prefix_len == '0) begin
				act_rec.prefix_start = '0;
			end
		end else begin
			act_rec.span_start   = head.cur;
			act_rec.token_index  = head.count;
			act_rec.is_new_token = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			tok_sent_q <= 1'b0;
		end else if (load) begin
			valid_q    <= 1'b1;
			tok_sent_q <= send_tok && head.act_v;
		end else if (!rec_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= send_tok ? tok_rec : act_rec;
		end
	end

	assign rec_valid = valid_q;
	assign rec       = rec_q;

endmodule

// ===== hdl/command_line_tokenizer.sv =====
// Top level of the command line tokenizer: front scanner, entry queue, back end.
// Depends on clt_pkg, clt_front, clt_queue, clt_back.
//
// Input channel (item_valid / item_stall / item): one line byte per beat, with
// the cursor and an end-of-line mark; has_byte 0 with end_of_line ends an
// empty line. Output channel (rec_valid / rec_stall / rec): token records as
// tokens finish, then one active-token record with last set per line.
// The front end takes one beat per cycle while item_stall is low; a beat that
// finishes a token or ends the line writes one entry into a QUEUE_DEPTH deep
// queue. The back end sends one record per cycle from the queue head while
// rec_stall is low, so a line end that also finishes a token yields two records
// from one entry. Each record passes through a queue entry and then the output
// register. The front end takes new beats while the queue has room; item_stall
// rises only while the queue is full.
// Reset clears scanner state, queue and output valid; the block is ready right
// after reset. A stall on rec_stall holds the output record;
// the queue then fills and back-pressures the input.
module command_line_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  clt_pkg::item_t    item,
	output logic              rec_valid,
	input  logic              rec_stall,
	output clt_pkg::record_t  rec
);
	import clt_pkg::*;

	entry_t push_entry, head;
	logic   push, pop, full, empty;

	assign item_stall = full;

	clt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.entry      (push_entry)
	);

	clt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	clt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

endmodule

// ===== verif/tb_command_line_tokenizer.sv =====
// Self-checking testbench for command_line_tokenizer: line bytes in, token and active records out.
// Depends on clt_pkg and the command_line_tokenizer RTL; holds its own tokenizer predictor.
module tb_command_line_tokenizer;
	import clt_pkg::*;

	// Predicts the records of each line and checks the records the block sends.
	class token_scoreboard;
		record_t     expected_recs[$];
		int          errors;
		int          lines, tokens, actives, unclosed, outside;

		scan_state_t scan;
		bit          esc;
		int          pos, tok_start, tok_count;
		bit          tok_flag;
		bit          hit, hit_lit;
		int          hit_idx, hit_start, hit_end;

		function new();
			errors = 0;
			lines = 0;
			tokens = 0;
			actives = 0;
			unclosed = 0;
			outside = 0;
			clear_line();
		endfunction

		function void clear_line();
			scan = ST_GAP;
			esc = 0;
			pos = 0;
			tok_start = 0;
			tok_flag = 0;
			tok_count = 0;
			hit = 0;
			hit_lit = 0;
			hit_idx = 0;
			hit_start = 0;
			hit_end = 0;
		endfunction

		function bit blank_char(logic [7:0] c);
			return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function record_t make_rec(logic kind, logic [1:0] ty, logic cl, int ss, int sl,
				int ps, int pl, int idx, logic nw, logic iq, logic lst);
			record_t r;
			r.record_kind   = kind;
			r.tok_type      = ty;
			r.closed        = cl;
			r.span_start    = POS_W'(ss);
			r.span_len      = POS_W'(sl);
			r.prefix_start  = POS_W'(ps);
			r.prefix_len    = POS_W'(pl);
			r.token_index   = IDX_W'(idx);
			r.is_new_token  = nw;
			r.inside_quotes = iq;
			r.last          = lst;
			return r;
		endfunction

		function void expect_rec(record_t r);
			expected_recs.insert(expected_recs.size(), r);
		endfunction

		// A finished token; the first one that covers the cursor becomes the match.
		function void close_token(logic [1:0] ty, logic cl, int s, int e, int cur);
			expect_rec(make_rec(REC_TOKEN, ty, cl, s, e - s, 0, 0, tok_count,
				1'b0, 1'b0, 1'b0));
			tokens++;
			if (!hit && cur >= s && cur <= e) begin
				hit = 1;
				hit_idx = tok_count;
				hit_start = s;
				hit_end = e;
				hit_lit = (ty == TOK_LIT);
			end
			if (tok_count < int'(TOKEN_LIM))
				tok_count++;
		endfunction

		function void note_item(item_t it);
			int p, cur, top, ps, pl;
			bit take, inq;
			p = pos;
			cur = int'(it.cursor);
			take = it.has_byte && pos < int'(LINE_LIM);
			if (take)
				pos++;
			if (it.end_of_line && cur > pos)
				cur = pos;
			if (take) begin
				if (esc)
					esc = 0;
				else if (it.ch == CH_BSLASH && scan != ST_SQ)
					esc = 1;
				else case (scan)
					ST_GAP: begin
						if (!blank_char(it.ch)) begin
							tok_start = p;
							tok_flag = 0;
							if (it.ch == CH_DQUOTE)
								scan = ST_DQ;
							else if (it.ch == CH_SQUOTE)
								scan = ST_SQ;
							else begin
								scan = ST_WORD;
								tok_flag = (it.ch == CH_DASH);
							end
						end
					end
					ST_WORD: begin
						if (blank_char(it.ch)) begin
							close_token(tok_flag ? TOK_FLAG : TOK_WORD, 1'b1, tok_start, p, cur);
							scan = ST_GAP;
						end
					end
					ST_DQ: begin
						if (it.ch == CH_DQUOTE) begin
							close_token(TOK_LIT, 1'b1, tok_start, p + 1, cur);
							scan = ST_GAP;
						end
					end
					default: begin
						if (it.ch == CH_SQUOTE) begin
							close_token(TOK_LIT, 1'b1, tok_start, p + 1, cur);
							scan = ST_GAP;
						end
					end
				endcase
			end
			if (it.end_of_line) begin
				inq = (scan == ST_DQ || scan == ST_SQ);
				if (scan == ST_WORD)
					close_token(tok_flag ? TOK_FLAG : TOK_WORD, 1'b1, tok_start, pos, cur);
				else if (inq) begin
					close_token(TOK_LIT, 1'b0, tok_start, pos, cur);
					unclosed++;
				end
				if (hit) begin
					top = cur < hit_end ? cur : hit_end;
					pl = top > hit_start ? top - hit_start : 0;
					ps = hit_start;
					// a literal's prefix starts after its opening quote
					if (pl > 0 && hit_lit) begin
						ps++;
						pl--;
					end
					if (pl == 0)
						ps = 0;
					expect_rec(make_rec(REC_ACTIVE, TOK_WORD, 1'b0, hit_start,
						hit_end - hit_start, ps, pl, hit_idx, 1'b0, inq, 1'b1));
				end else begin
					expect_rec(make_rec(REC_ACTIVE, TOK_WORD, 1'b0, cur, 0, 0, 0,
						tok_count, 1'b1, inq, 1'b1));
					outside++;
				end
				actives++;
				lines++;
				clear_line();
			end
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_record(record_t got);
			record_t want;
			if (expected_recs.size() == 0) begin
				$error("record arrived with nothing outstanding: %p", got);
				errors++;
			end else begin
				want = expected_recs.pop_front();
				cmp("record_kind", 16'(want.record_kind), 16'(got.record_kind));
				cmp("tok_type", 16'(want.tok_type), 16'(got.tok_type));
				cmp("closed", 16'(want.closed), 16'(got.closed));
				cmp("span_start", 16'(want.span_start), 16'(got.span_start));
				cmp("span_len", 16'(want.span_len), 16'(got.span_len));
				cmp("prefix_start", 16'(want.prefix_start), 16'(got.prefix_start));
				cmp("prefix_len", 16'(want.prefix_len), 16'(got.prefix_len));
				cmp("token_index", 16'(want.token_index), 16'(got.token_index));
				cmp("is_new_token", 16'(want.is_new_token), 16'(got.is_new_token));
				cmp("inside_quotes", 16'(want.inside_quotes), 16'(got.inside_quotes));
				cmp("last", 16'(want.last), 16'(got.last));
			end
		endfunction

		function int pending();
			return expected_recs.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    rec_valid;
	logic    rec_stall;
	record_t rec;

	token_scoreboard sb;
	logic [7:0]      line_bytes[$];
	int              items_sent;
	int              rx_hold;
	bit              tx_steady, rx_steady;

	command_line_tokenizer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rec_valid && !rec_stall)
			sb.check_record(rec);
	end

	function automatic void add_byte(input logic [7:0] b);
		line_bytes.insert(line_bytes.size(), b);
	endfunction

	// Sends one beat; entered and left at a falling edge.
	task automatic push_item(input item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		if (it.has_byte || it.end_of_line)
			items_sent++;
		@(negedge clk);
	endtask

	// Sends line_bytes as one line; wander gives every beat its own cursor.
	task automatic send_line(input int cur, input bit wander);
		item_t it;
		int n;
		n = line_bytes.size();
		if (n == 0) begin
			it = '0;
			it.ch = 8'($urandom_range(0, 255));
			it.cursor = POS_W'(cur);
			it.end_of_line = 1'b1;
			push_item(it);
		end else begin
			for (int i = 0; i < n; i++) begin
				// occasional beat with no byte and no line end: ignored
				if ($urandom_range(0, 15) == 0) begin
					it = '0;
					it.ch = 8'($urandom_range(0, 255));
					it.cursor = POS_W'($urandom_range(0, 8191));
					push_item(it);
				end
				it.has_byte = 1'b1;
				it.ch = line_bytes[i];
				if (wander)
					it.cursor = ($urandom_range(0, 7) == 0) ? POS_W'($urandom_range(0, 8191))
						: POS_W'($urandom_range(0, n + 1));
				else
					it.cursor = POS_W'(cur);
				it.end_of_line = (i == n - 1);
				push_item(it);
			end
		end
	endtask

	task automatic send_text(input string s, input int cur, input bit wander);
		line_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
		send_line(cur, wander);
	endtask

	// Drops valid and waits until every predicted record has been seen.
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] any_letter();
		return ($urandom_range(0, 4) == 0) ? 8'(8'h30 + $urandom_range(0, 9))
			: 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] any_blank();
		return ($urandom_range(0, 5) == 0) ? 8'h20 : 8'(8'h08 + $urandom_range(1, 5));
	endfunction

	function automatic logic [7:0] quoted_char();
		case ($urandom_range(0, 9))
			0:       return 8'h20;
			1:       return CH_BSLASH;
			2:       return CH_DASH;
			3:       return CH_DQUOTE;
			4:       return CH_SQUOTE;
			default: return any_letter();
		endcase
	endfunction

	// Mostly well-formed fragments: words, flags, quoted strings, escapes, blanks.
	task automatic build_random_line();
		int nfrag;
		logic [7:0] quote_ch;
		line_bytes.delete();
		nfrag = $urandom_range(0, 6);
		repeat (nfrag) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if ($urandom_range(0, 3) == 0)
						add_byte(CH_DASH);
					repeat ($urandom_range(1, 5)) add_byte(any_letter());
				end
				3, 4: begin
					quote_ch = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					add_byte(quote_ch);
					repeat ($urandom_range(0, 5)) add_byte(quoted_char());
					if ($urandom_range(0, 3) != 0)
						add_byte(quote_ch);
				end
				5: begin
					add_byte(CH_BSLASH);
					add_byte(8'($urandom_range(0, 255)));
				end
				6:
					add_byte(8'($urandom_range(0, 255)));
				default:
					repeat ($urandom_range(1, 3)) add_byte(any_blank());
			endcase
		end
	endtask

	// Receiver: per record a random stall, with a long hold-off on request.
	initial begin
		int n, used_hold;
		rec_stall = 1'b0;
		rx_steady = 0;
		used_hold = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold != used_hold) begin
				n = rx_hold;
				used_hold = rx_hold;
			end else begin
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				n = rx_steady ? 0 : $urandom_range(0, 4);
			end
			if (n > 0) begin
				rec_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			rec_stall <= 1'b0;
			do @(posedge clk); while (!rec_valid);
			@(negedge clk);
		end
	end

	initial begin
		#8000000;
		$display("tb_command_line_tokenizer failed");
		$finish;
	end

	initial begin
		int random_base, n, r;
		bit paused, held;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		items_sent = 0;
		rx_hold = 0;
		tx_steady = 0;
		paused = 0;
		held = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("", 0, 0);                    // empty line
		send_text("-v", 1, 0);                  // flag under the cursor
		send_text("'\\' x", 1, 0);              // backslash is plain inside single quotes
		send_text("\"q\\\"\"", 8191, 0);       // escaped quote, cursor clamped to line end
		send_text("\\ a\\", 0, 0);              // escaped blank starts nothing; trailing escape
		send_text("'ab", 1, 0);                 // unclosed quote, prefix empty after the quote
		send_text("ab cd", 0, 1);               // cursor moves within the line
		line_bytes = '{8'hFF, 8'h00};
		send_line(8191, 0);

		random_base = items_sent;
		rx_hold = 60;
		while (items_sent < random_base + 1100) begin
			if (!paused && items_sent > random_base + 550) begin
				paused = 1;
				wait_drained();
			end
			if (!held && items_sent > random_base + 800) begin
				held = 1;
				rx_hold = 90;
			end
			build_random_line();
			n = line_bytes.size();
			r = $urandom_range(0, 19);
			if (r < 12)
				send_line($urandom_range(0, n + 1), 0);
			else if (r < 15)
				send_line(0, 0);
			else if (r < 17)
				send_line($urandom_range(0, 8191), 0);
			else
				send_line(0, 1);
		end

		wait_drained();
		if (sb.pending() != 0) begin
			$error("%0d records never arrived", sb.pending());
			sb.errors++;
		end
		$display("Ran %0d lines (%0d beats): %0d token and %0d active records.",
			sb.lines, items_sent, sb.tokens, sb.actives);
		$display("Seen %0d unclosed quotes and %0d cursors outside every token.",
			sb.unclosed, sb.outside);
		if (sb.errors == 0)
			$display("tb_command_line_tokenizer passed");
		else
			$display("tb_command_line_tokenizer failed");
		$finish;
	end

endmodule
